/* sv/sector_interleave_table_builder_assert.svh */
// ----------------------------------------------------------------------------
// Sector interleave table builder assertion macros
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef SECTOR_INTERLEAVE_TABLE_BUILDER_ASSERT_SVH
`define SECTOR_INTERLEAVE_TABLE_BUILDER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define SITB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sector interleave table builder assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SITB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sector interleave table builder assertion failed");

`else

`define SITB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SITB_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* sv/sitb_pkg.sv */
// ----------------------------------------------------------------------------
// Sector interleave table builder package
// Shared widths, limits and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sitb_pkg;

    localparam int SECTOR_W      = 6;
    localparam int SLOT_W        = 5;
    localparam int ILV_W         = 4;
    localparam int RESULT_CAP    = 32;
    localparam int MAX_SLOTS_DEF = 32;

    typedef struct packed {
        logic load;    // capture count, clear marks, start a build
        logic reduce;  // subtract count from the step
        logic place;   // write the current sector at the current slot
        logic probe;   // move the slot pointer one slot forward
        logic emit;    // read one table entry out
    } sitb_cmd_t;

    typedef struct packed {
        logic count_zero;   // incoming count is zero
        logic step_ge_n;    // step not yet reduced below the count
        logic last_sector;  // the sector being placed is the final one
        logic pos_used;     // slot under the pointer is occupied
        logic emit_last;    // entry being read is the final slot
    } sitb_stat_t;

endpackage

/* sv/sitb_ctrl.sv */
// ----------------------------------------------------------------------------
// Sector interleave table builder controller
// Sequences step reduction, placement, probing and table readout.
// ----------------------------------------------------------------------------
module sitb_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  sitb_pkg::sitb_stat_t stat,
    output sitb_pkg::sitb_cmd_t  cmd,
    output logic                 busy
);
    import sitb_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_STEP  = 3'd1;
    localparam logic [2:0] ST_PLACE = 3'd2;
    localparam logic [2:0] ST_PROBE = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && !stat.count_zero)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (stat.step_ge_n)
                begin
                    cmd.reduce = 1'b1;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = stat.last_sector ? ST_EMIT : ST_PROBE;
            end
            ST_PROBE:
            begin
                if (stat.pos_used)
                begin
                    cmd.probe = 1'b1;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (stat.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* sv/sitb_datapath.sv */
// ----------------------------------------------------------------------------
// Sector interleave table builder datapath
// Holds the interleave register, slot pointer, occupancy marks, the slot
// table memory and the registered result outputs.
// ----------------------------------------------------------------------------
module sitb_datapath
#(
    parameter int MAX_SLOTS = sitb_pkg::MAX_SLOTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sitb_pkg::ILV_W-1:0]    cfg_data,
    input  logic [sitb_pkg::SECTOR_W-1:0] sector_count,
    input  sitb_pkg::sitb_cmd_t           cmd,
    output sitb_pkg::sitb_stat_t          stat,
    output logic                          result_valid,
    output logic [sitb_pkg::SLOT_W-1:0]   slot,
    output logic [sitb_pkg::SECTOR_W-1:0] sector_number,
    output logic                          last
);
    import sitb_pkg::*;

    localparam int LIM = (MAX_SLOTS < RESULT_CAP) ? MAX_SLOTS : RESULT_CAP;
    localparam int PW  = $clog2(LIM);
    localparam int CW  = $clog2(LIM + 1);
    localparam int SW  = PW + 1;

    logic [ILV_W-1:0]    ilv_reg;
    logic [CW-1:0]       n_reg;
    logic [SECTOR_W-1:0] step_reg;
    logic [PW-1:0]       pos_reg;
    logic [CW-1:0]       sec_reg;
    logic [PW-1:0]       idx_reg;
    logic [LIM-1:0]      used_reg;
    logic                out_valid_reg;
    logic [PW-1:0]       out_slot_reg;
    logic                out_last_reg;
    logic [SECTOR_W-1:0] rd_data_reg;
    logic [SECTOR_W-1:0] slot_mem [LIM];

    logic [SECTOR_W-1:0] count_sat;
    logic [SW-1:0]       n_ext;
    logic [SW-1:0]       adv_sum;
    logic [PW-1:0]       pos_adv;
    logic [SW-1:0]       inc_sum;
    logic [PW-1:0]       pos_inc;

    assign count_sat = (sector_count > SECTOR_W'(LIM)) ? SECTOR_W'(LIM) : sector_count;
    assign n_ext     = SW'(n_reg);

    // The reduced step is below the count, so the sum stays below twice the count.
    assign adv_sum = SW'(pos_reg) + SW'(step_reg[PW-1:0]);
    assign pos_adv = (adv_sum >= n_ext) ? PW'(adv_sum - n_ext) : PW'(adv_sum);
    assign inc_sum = SW'(pos_reg) + SW'(1);
    assign pos_inc = (inc_sum >= n_ext) ? '0 : PW'(inc_sum);

    assign stat.count_zero  = (sector_count == '0);
    assign stat.step_ge_n   = (step_reg >= SECTOR_W'(n_reg));
    assign stat.last_sector = (sec_reg == n_reg);
    assign stat.pos_used    = used_reg[pos_reg];
    assign stat.emit_last   = (SW'(idx_reg) + SW'(1) == n_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ilv_reg <= '0;
        end
        else if (cfg_we)
        begin
            ilv_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.emit;
            if (cmd.load)
            begin
                used_reg <= '0;
            end
            else if (cmd.place)
            begin
                used_reg[pos_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg    <= CW'(count_sat);
            step_reg <= SECTOR_W'(ilv_reg) + SECTOR_W'(1);
            pos_reg  <= '0;
            sec_reg  <= CW'(1);
            idx_reg  <= '0;
        end
        else
        begin
            if (cmd.reduce)
            begin
                step_reg <= step_reg - SECTOR_W'(n_reg);
            end
            if (cmd.place && !stat.last_sector)
            begin
                pos_reg <= pos_adv;
                sec_reg <= sec_reg + CW'(1);
            end
            else if (cmd.probe)
            begin
                pos_reg <= pos_inc;
            end
            if (cmd.emit)
            begin
                idx_reg <= idx_reg + PW'(1);
            end
        end
        if (cmd.emit)
        begin
            out_slot_reg <= idx_reg;
            out_last_reg <= stat.emit_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.place)
        begin
            slot_mem[pos_reg] <= SECTOR_W'(sec_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rd_data_reg <= slot_mem[idx_reg];
        end
    end

    assign result_valid  = out_valid_reg;
    assign slot          = SLOT_W'(out_slot_reg);
    assign sector_number = rd_data_reg;
    assign last          = out_last_reg;

endmodule

/* sv/sector_interleave_table_builder.sv */
// ----------------------------------------------------------------------------
// Sector interleave table builder
// Lays logical sectors onto the physical slots of a track with a
// configurable interleave, then reads the table out one slot per beat.
// ----------------------------------------------------------------------------
// Channel   Signals                               Handshake
// input     start, sector_count                   start && !busy
// result    result_valid, slot, sector_number,    one-cycle strobe
//           last
// config    cfg_valid, cfg_data, cfg_ready        cfg_valid && cfg_ready
//
// A build runs a load step, subtracts the count from the step (interleave + 1)
// until the step state sees it below the count, places each sector, after each
// placement but the last tests the new slot and probes forward while it is taken,
// then reads every slot out; each beat is registered from its read.
// After reset no build is active and the interleave is zero.
// Results cannot be stalled; busy falls in the cycle that carries the final beat.
// ----------------------------------------------------------------------------
module sector_interleave_table_builder
#(
    parameter int MAX_SLOTS = sitb_pkg::MAX_SLOTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sitb_pkg::SECTOR_W-1:0] sector_count,
    output logic                          result_valid,
    output logic [sitb_pkg::SLOT_W-1:0]   slot,
    output logic [sitb_pkg::SECTOR_W-1:0] sector_number,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sitb_pkg::ILV_W-1:0]    cfg_data
);
    import sitb_pkg::*;

    `include "sector_interleave_table_builder_assert.svh"

    sitb_cmd_t  cmd;
    sitb_stat_t stat;

    assign cfg_ready = 1'b1;

    sitb_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    sitb_datapath
    #(
        .MAX_SLOTS (MAX_SLOTS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .sector_count  (sector_count),
        .cmd           (cmd),
        .stat          (stat),
        .result_valid  (result_valid),
        .slot          (slot),
        .sector_number (sector_number),
        .last          (last)
    );

    // Every beat but the final one is issued while the build is still active.
    `SITB_ASSERT_IMP(a_beat_while_busy, clk, rst_n, result_valid && !last, busy)
    // The final beat of a table is never followed directly by another beat.
    `SITB_ASSERT_NXT(a_last_ends_burst, clk, rst_n, result_valid && last, !result_valid)
    // A zero count starts nothing.
    `SITB_ASSERT_NXT(a_zero_count_idle, clk, rst_n,
                     start && !busy && (sector_count == '0), !busy)
    // A sector is only ever written into a free slot.
    `SITB_ASSERT_IMP(a_place_free_slot, clk, rst_n, cmd.place, !stat.pos_used)

endmodule

/* tb/sv/sector_interleave_table_builder_tb.sv */
// ----------------------------------------------------------------------------
// Sector interleave table builder testbench
// Drives sector counts through the start/busy port while the interleave
// register is changed between phases. A table of directed cases comes first,
// then random counts in bursts, with random gaps in most phases. Each result
// beat is compared with the slot layout that the testbench computes or has typed in.
// ----------------------------------------------------------------------------
module sector_interleave_table_builder_tb;

    import sitb_pkg::*;

    localparam int SLOT_LIMIT    = (MAX_SLOTS_DEF < RESULT_CAP) ? MAX_SLOTS_DEF : RESULT_CAP;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 36;
    localparam int REPORT_MAX    = 10;
    localparam int DIRECTED_ROWS = 21;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [SECTOR_W-1:0] sector_number;
        logic                last;
    } table_entry_t;

    typedef logic [0:7][SECTOR_W-1:0] short_layout_t;

    // A row with known set carries its layout typed in, slot 0 first.
    typedef struct packed {
        logic [ILV_W-1:0]    ilv;
        logic [SECTOR_W-1:0] cnt;
        logic                known;
        short_layout_t       layout;
    } directed_row_t;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{4'd0,  6'd1,  1'b1, {6'd1, 42'd0}},
        '{4'd0,  6'd2,  1'b1, {6'd1, 6'd2, 36'd0}},
        '{4'd0,  6'd0,  1'b1, 48'd0},
        '{4'd1,  6'd4,  1'b1, {6'd1, 6'd3, 6'd2, 6'd4, 24'd0}},
        '{4'd1,  6'd5,  1'b1, {6'd1, 6'd4, 6'd2, 6'd5, 6'd3, 18'd0}},
        '{4'd2,  6'd6,  1'b1, {6'd1, 6'd3, 6'd5, 6'd2, 6'd4, 6'd6, 12'd0}},
        '{4'd3,  6'd4,  1'b1, {6'd1, 6'd2, 6'd3, 6'd4, 24'd0}},
        '{4'd15, 6'd1,  1'b1, {6'd1, 42'd0}},
        '{4'd15, 6'd3,  1'b1, {6'd1, 6'd2, 6'd3, 30'd0}},
        '{4'd15, 6'd0,  1'b1, 48'd0},
        '{4'd15, 6'd32, 1'b0, 48'd0},
        '{4'd15, 6'd63, 1'b0, 48'd0},
        '{4'd15, 6'd16, 1'b0, 48'd0},
        '{4'd0,  6'd32, 1'b0, 48'd0},
        '{4'd0,  6'd33, 1'b0, 48'd0},
        '{4'd0,  6'd63, 1'b0, 48'd0},
        '{4'd7,  6'd21, 1'b0, 48'd0},
        '{4'd7,  6'd42, 1'b0, 48'd0},
        '{4'd5,  6'd31, 1'b0, 48'd0},
        '{4'd10, 6'd17, 1'b0, 48'd0},
        '{4'd9,  6'd8,  1'b0, 48'd0}
    };

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [SECTOR_W-1:0] sector_count;
    logic                result_valid;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] sector_number;
    logic                last;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [ILV_W-1:0]    cfg_data;

    table_entry_t     pending_entries [$];
    logic [ILV_W-1:0] interleave_setting;
    int               mismatches;
    int               builds;
    int               zero_builds;
    int               saturated_builds;
    int               entries_checked;
    int               interleave_writes;
    int               burst_left;
    bit               gaps_on;
    longint           cycle_count;

    sector_interleave_table_builder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .sector_count  (sector_count),
        .result_valid  (result_valid),
        .slot          (slot),
        .sector_number (sector_number),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d table entries still pending",
                     cycle_count, pending_entries.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Lays sectors 1..n onto the slots and queues one entry per slot.
    function automatic void predict_layout(input logic [SECTOR_W-1:0] cnt);
        logic [SECTOR_W-1:0]   layout [SLOT_LIMIT];
        logic [SLOT_LIMIT-1:0] taken;
        int                    n;
        int                    step;
        int                    pos;
        int                    probes;
        table_entry_t          entry;
        n = int'(cnt);
        if (n == 0)
            return;
        if (n > SLOT_LIMIT)
            n = SLOT_LIMIT;
        step = (int'(interleave_setting) + 1) % n;
        taken = '0;
        pos = 0;
        foreach (layout[i])
            layout[i] = '0;
        for (int sec = 1; sec <= n; sec++)
        begin
            layout[pos] = SECTOR_W'(sec);
            taken[pos] = 1'b1;
            if (sec == n)
                break;
            pos = (pos + step) % n;
            probes = 0;
            while (probes < n && taken[pos])
            begin
                pos = (pos + 1) % n;
                probes++;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            entry.slot = SLOT_W'(i);
            entry.sector_number = layout[i];
            entry.last = (i == n - 1);
            pending_entries.push_back(entry);
        end
    endfunction

    function automatic logic [SECTOR_W-1:0] random_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return '0;
        else if (pick < 15)
            return SECTOR_W'($urandom_range(SLOT_LIMIT + 1, 63));
        else if (pick < 40)
            return SECTOR_W'($urandom_range(13, SLOT_LIMIT));
        else
            return SECTOR_W'($urandom_range(1, 12));
    endfunction

    task automatic send_count(input logic [SECTOR_W-1:0] cnt, input bit known,
                              input short_layout_t layout);
        table_entry_t entry;
        @(negedge clk);
        start <= 1'b1;
        sector_count <= cnt;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (known)
        begin
            for (int i = 0; i < int'(cnt); i++)
            begin
                entry.slot = SLOT_W'(i);
                entry.sector_number = layout[i];
                entry.last = (i == int'(cnt) - 1);
                pending_entries.push_back(entry);
            end
        end
        else
        begin
            predict_layout(cnt);
        end
        builds++;
        if (cnt == 0)
            zero_builds++;
        if (cnt > SLOT_LIMIT)
            saturated_builds++;
    endtask

    // The sender works in bursts; when gaps are on, start drops for a random gap between bursts.
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            if (gaps_on)
            begin
                gap = $urandom_range(1, 12);
                @(negedge clk);
                start <= 1'b0;
                sector_count <= SECTOR_W'($urandom);
                repeat (gap - 1)
                    @(negedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic lower_start();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending_entries.size() != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_interleave(input logic [ILV_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        interleave_setting = value;
        interleave_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        table_entry_t want;
        if (rst_n && result_valid)
        begin
            if (pending_entries.size() == 0)
            begin
                if (mismatches < REPORT_MAX)
                    $display("Unexpected beat: slot %0d sector %0d last %0b",
                             slot, sector_number, last);
                mismatches++;
            end
            else
            begin
                want = pending_entries.pop_front();
                entries_checked++;
                if (slot !== want.slot || sector_number !== want.sector_number
                    || last !== want.last)
                begin
                    if (mismatches < REPORT_MAX)
                        $display("Mismatch: expected slot %0d sector %0d last %0b, %s %0d %0d %0b",
                                 want.slot, want.sector_number, want.last,
                                 "got", slot, sector_number, last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        logic [ILV_W-1:0] ilv;
        rst_n = 1'b0;
        start = 1'b0;
        sector_count = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        interleave_setting = '0;
        mismatches = 0;
        builds = 0;
        zero_builds = 0;
        saturated_builds = 0;
        entries_checked = 0;
        interleave_writes = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        cycle_count = 0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (r == 0 || directed_rows[r].ilv != interleave_setting)
            begin
                lower_start();
                wait_idle();
                write_interleave(directed_rows[r].ilv);
            end
            pace();
            send_count(directed_rows[r].cnt, directed_rows[r].known,
                       directed_rows[r].layout);
        end

        // Every third phase runs back to back with no sender gaps.
        for (int p = 0; p < PHASES; p++)
        begin
            lower_start();
            wait_idle();
            if (p == 0)
                ilv = '1;
            else if (p == 1)
                ilv = '0;
            else
                ilv = ILV_W'($urandom_range(0, 15));
            write_interleave(ilv);
            gaps_on = (p % 3 != 2);
            burst_left = 0;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                pace();
                send_count(random_count(), 1'b0, '0);
            end
        end

        lower_start();
        wait_idle();
        if (pending_entries.size() != 0)
        begin
            $display("%0d table entries never arrived", pending_entries.size());
            mismatches += pending_entries.size();
        end
        $display("Ran %0d builds (%0d with zero count, %0d above the slot limit) over %0d %s",
                 builds, zero_builds, saturated_builds, interleave_writes,
                 "interleave writes");
        $display("Checked %0d table entries, %0d errors", entries_checked, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/sitb_pkg.sv
sv/sitb_ctrl.sv
sv/sitb_datapath.sv
sv/sector_interleave_table_builder.sv
tb/sv/sector_interleave_table_builder_tb.sv
